>>> src/assert_macros.svh
// assertion helper macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/ffprr_pkg.sv
// ---------------------------------------------------------------------------
// ffprr_pkg
// shared types and constants of the first-fit partition allocator
// ---------------------------------------------------------------------------
package ffprr_pkg;

    localparam int ENTRIES_DEF       = 32;
    localparam int SIZE_WIDTH_DEF    = 16;
    localparam int QUANTUM_WIDTH_DEF = 8;
    localparam int ID_WIDTH          = 16;
    localparam logic [15:0] MEM_SIZE_RESET = 16'd1024;

    typedef enum logic [1:0] {
        KIND_UNUSED = 2'd0,
        KIND_HOLE   = 2'd1,
        KIND_OCC    = 2'd2
    } kind_t;

    // controller states, one-hot
    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_CLEAR  = 8'b0000_0010,
        ST_FIT    = 8'b0000_0100,
        ST_PLACE  = 8'b0000_1000,
        ST_RUN    = 8'b0001_0000,
        ST_RETIRE = 8'b0010_0000,
        ST_PACK   = 8'b0100_0000,
        ST_OUT    = 8'b1000_0000
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic clear;      // reset table to one hole, or empty for size zero
        logic start;      // latch request, reset scan index
        logic fit_step;   // inspect one entry for first fit
        logic place_step; // shift one entry / write placement
        logic run_step;   // inspect one entry for round robin
        logic retire;     // apply run result
        logic pack_step;  // compact one entry
        logic out_load;   // load result register
    } cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic scan_last;  // scan index at last entry
        logic fit_found;  // first fit located
        logic place_done; // placement finished
        logic run_found;  // round robin target located
    } stat_t;

endpackage

>>> src/first_fit_partition_round_robin_top.sv
// ---------------------------------------------------------------------------
// first_fit_partition_round_robin_top
// first-fit variable partition allocator with round-robin quantum scheduler
// ---------------------------------------------------------------------------
// Each accepted input transfer is one scheduler tick and yields exactly one
// output transfer. A tick walks the segment table one entry per cycle with the
// single read index: a first fit search and the right shift for a split (only
// for a valid request), a round-robin search, a retire step (only when a
// target is found) and a compaction pass. A new input transfer is taken only
// after the previous result has left the output register.
// A cfg write (taken only while idle) reloads the table with one hole, or with none for a zero size.
// ---------------------------------------------------------------------------
module first_fit_partition_round_robin_top
    import ffprr_pkg::*;
#(
    parameter int ENTRIES       = ENTRIES_DEF,
    parameter int SIZE_WIDTH    = SIZE_WIDTH_DEF,
    parameter int QUANTUM_WIDTH = QUANTUM_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // cfg: memory_size
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    // tuser: request_valid ; tdata: request_size, request_quantum
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic        s_axis_tuser,
    input  logic [SIZE_WIDTH+QUANTUM_WIDTH-1:0] s_axis_tdata,
    // tdata: admitted, admitted_id, no_room, ran_valid, ran_id, ran_left,
    //        ran_done, free_memory, active_count (then zero fill)
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [((ID_WIDTH*2+SIZE_WIDTH+QUANTUM_WIDTH+$clog2(ENTRIES+1)+4+7)/8)*8-1:0]
                        m_axis_tdata
);

    localparam int RW = ID_WIDTH*2 + SIZE_WIDTH + QUANTUM_WIDTH + $clog2(ENTRIES+1) + 4;
    localparam int OW = ((RW + 7) / 8) * 8;

    cmd_t  cmd;
    stat_t stat;
    logic  idle, in_fire, cfg_fire, out_valid_reg;
    logic [RW-1:0] result;

    // one tick in flight; result register holds until taken
    // a pending cfg write wins over an input transfer
    assign s_axis_tready = idle && !cfg_valid;
    assign cfg_ready     = idle;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_fire      = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OW'(result);

    ffprr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_fire  (cfg_fire),
        .in_fire   (in_fire),
        .out_busy  (out_valid_reg),
        .req_valid (s_axis_tuser),
        .stat      (stat),
        .cmd       (cmd),
        .idle      (idle)
    );

    ffprr_dp #(
        .ENTRIES       (ENTRIES),
        .SIZE_WIDTH    (SIZE_WIDTH),
        .QUANTUM_WIDTH (QUANTUM_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_data    (cfg_data),
        .req_valid   (s_axis_tuser),
        .req_size    (s_axis_tdata[SIZE_WIDTH-1:0]),
        .req_quantum (s_axis_tdata[SIZE_WIDTH+QUANTUM_WIDTH-1:SIZE_WIDTH]),
        .result      (result)
    );

endmodule

>>> src/ffprr_ctrl.sv
// ---------------------------------------------------------------------------
// ffprr_ctrl
// sequencer for fit, place, run and compact passes
// ---------------------------------------------------------------------------
module ffprr_ctrl
    import ffprr_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cfg_fire,
    input  logic  in_fire,
    input  logic  out_busy,
    input  logic  req_valid,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  idle
);
`include "assert_macros.svh"

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        idle = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                idle = !out_busy;
                if (cfg_fire)
                begin
                    cmd.clear = 1'b1;
                end
                else if (in_fire)
                begin
                    cmd.start = 1'b1;
                    state_next = req_valid ? ST_FIT : ST_RUN;
                end
            end
            ST_CLEAR:
                state_next = ST_IDLE;
            ST_FIT:
            begin
                cmd.fit_step = 1'b1;
                if (stat.fit_found)
                    state_next = ST_PLACE;
                else if (stat.scan_last)
                    state_next = ST_RUN;
            end
            ST_PLACE:
            begin
                cmd.place_step = 1'b1;
                if (stat.place_done)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                cmd.run_step = 1'b1;
                if (stat.run_found)
                    state_next = ST_RETIRE;
                else if (stat.scan_last)
                    state_next = ST_PACK;
            end
            ST_RETIRE:
            begin
                cmd.retire = 1'b1;
                state_next = ST_PACK;
            end
            ST_PACK:
            begin
                cmd.pack_step = 1'b1;
                if (stat.scan_last)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    `ASSERT_CLK(a_onehot, clk, rst_n, $onehot(state_reg), "state not one-hot")
    `ASSERT_NEXT(a_out_idle, clk, rst_n, cmd.out_load, state_reg == ST_IDLE,
        "result load not followed by idle")
    `ASSERT_CLK(a_idle_only, clk, rst_n, !idle || state_reg == ST_IDLE,
        "ready outside idle")

endmodule

>>> src/ffprr_dp.sv
// ---------------------------------------------------------------------------
// ffprr_dp
// segment table, scan index and result register
// ---------------------------------------------------------------------------
module ffprr_dp
    import ffprr_pkg::*;
#(
    parameter int ENTRIES       = ENTRIES_DEF,
    parameter int SIZE_WIDTH    = SIZE_WIDTH_DEF,
    parameter int QUANTUM_WIDTH = QUANTUM_WIDTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cmd_t                     cmd,
    output stat_t                    stat,
    input  logic [15:0]              cfg_data,
    input  logic                     req_valid,
    input  logic [SIZE_WIDTH-1:0]    req_size,
    input  logic [QUANTUM_WIDTH-1:0] req_quantum,
    output logic [2*ID_WIDTH+SIZE_WIDTH+QUANTUM_WIDTH+$clog2(ENTRIES+1)+3:0] result
);
`include "assert_macros.svh"

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    kind_t                    kind_reg   [ENTRIES];
    logic [SIZE_WIDTH-1:0]    size_reg   [ENTRIES];
    logic [ID_WIDTH-1:0]      owner_reg  [ENTRIES];
    logic [QUANTUM_WIDTH-1:0] quanta_reg [ENTRIES];

    logic [SIZE_WIDTH-1:0]    mem_size_reg;
    logic [SIZE_WIDTH-1:0]    free_reg;
    logic [CW-1:0]            active_reg;
    logic [CW-1:0]            turn_reg;
    logic [ID_WIDTH-1:0]      last_owner_reg;
    logic [IW-1:0]            idx_reg;   // read index
    logic [IW-1:0]            wr_reg;    // compaction write index
    logic [IW-1:0]            pos_reg;   // placement position
    logic [CW-1:0]            count_reg; // occupied entries seen
    logic                     wr_any_reg;
    logic                     rv_reg;
    logic [SIZE_WIDTH-1:0]    rsize_reg;
    logic [QUANTUM_WIDTH-1:0] rq_reg;
    logic [SIZE_WIDTH-1:0]    rest_reg;
    logic                     adm_reg, noroom_reg;
    logic [ID_WIDTH-1:0]      adm_id_reg;
    logic                     ran_reg, done_reg;
    logic [ID_WIDTH-1:0]      ran_id_reg;
    logic [QUANTUM_WIDTH-1:0] ran_left_reg;
    logic [IW-1:0]            ran_pos_reg;
    logic [2*ID_WIDTH+SIZE_WIDTH+QUANTUM_WIDTH+CW+3:0] result_reg;

    logic fit_hit, run_hit, is_occ;
    logic [ID_WIDTH-1:0] next_id;
    logic [SIZE_WIDTH-1:0] rest_w;
    logic [CW-1:0] turn_eff;

    assign result = result_reg;
    assign is_occ  = kind_reg[idx_reg] == KIND_OCC;
    assign fit_hit = kind_reg[idx_reg] == KIND_HOLE && rsize_reg != '0
                     && size_reg[idx_reg] >= rsize_reg;
    assign turn_eff = (turn_reg > active_reg || turn_reg == '0) ? CW'(1) : turn_reg;
    assign run_hit = is_occ && active_reg != '0 && (count_reg + CW'(1)) == turn_eff;
    assign next_id = (last_owner_reg + 1'b1 == '0) ? ID_WIDTH'(1) : last_owner_reg + 1'b1;
    assign rest_w  = size_reg[idx_reg] - rsize_reg;

    assign stat.scan_last  = idx_reg == LAST;
    assign stat.fit_found  = fit_hit;
    assign stat.place_done = idx_reg == pos_reg;
    assign stat.run_found  = run_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                kind_reg[i]   <= (i == 0) ? KIND_HOLE : KIND_UNUSED;
                size_reg[i]   <= (i == 0) ? SIZE_WIDTH'(MEM_SIZE_RESET) : '0;
                owner_reg[i]  <= '0;
                quanta_reg[i] <= '0;
            end
            mem_size_reg   <= SIZE_WIDTH'(MEM_SIZE_RESET);
            free_reg       <= SIZE_WIDTH'(MEM_SIZE_RESET);
            active_reg     <= '0;
            turn_reg       <= CW'(1);
            last_owner_reg <= '0;
            idx_reg        <= '0;
            wr_reg         <= '0;
            pos_reg        <= '0;
            count_reg      <= '0;
            wr_any_reg     <= 1'b0;
            rv_reg         <= 1'b0;
            rsize_reg      <= '0;
            rq_reg         <= '0;
            rest_reg       <= '0;
            adm_reg        <= 1'b0;
            noroom_reg     <= 1'b0;
            adm_id_reg     <= '0;
            ran_reg        <= 1'b0;
            done_reg       <= 1'b0;
            ran_id_reg     <= '0;
            ran_left_reg   <= '0;
            ran_pos_reg    <= '0;
            result_reg     <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                for (int i = 0; i < ENTRIES; i++)
                begin
                    kind_reg[i]   <= KIND_UNUSED;
                    size_reg[i]   <= '0;
                    owner_reg[i]  <= '0;
                    quanta_reg[i] <= '0;
                end
                // zero size leaves an empty table after compaction
                kind_reg[0]    <= (SIZE_WIDTH'(cfg_data) != '0) ? KIND_HOLE : KIND_UNUSED;
                size_reg[0]    <= SIZE_WIDTH'(cfg_data);
                mem_size_reg   <= SIZE_WIDTH'(cfg_data);
                free_reg       <= SIZE_WIDTH'(cfg_data);
                active_reg     <= '0;
                turn_reg       <= CW'(1);
                last_owner_reg <= '0;
            end
            if (cmd.start)
            begin
                idx_reg    <= '0;
                count_reg  <= '0;
                rv_reg     <= req_valid;
                rsize_reg  <= req_size;
                rq_reg     <= (req_quantum == '0) ? QUANTUM_WIDTH'(1) : req_quantum;
                adm_reg    <= 1'b0;
                adm_id_reg <= '0;
                noroom_reg <= req_valid;
                ran_reg    <= 1'b0;
                done_reg   <= 1'b0;
                ran_id_reg <= '0;
                ran_left_reg <= '0;
            end
            if (cmd.fit_step)
            begin
                if (fit_hit)
                begin
                    pos_reg  <= idx_reg;
                    rest_reg <= rest_w;
                    if (rest_w == '0)
                    begin
                        idx_reg <= idx_reg;  // place finishes at once
                    end
                    else if (kind_reg[ENTRIES-1] != KIND_UNUSED || idx_reg == LAST)
                    begin
                        // no slot for the remainder: refuse, the place step then ends at once
                        pos_reg <= idx_reg;
                    end
                    else
                    begin
                        idx_reg <= LAST;
                    end
                    if (rest_w != '0 &&
                        (kind_reg[ENTRIES-1] != KIND_UNUSED || idx_reg == LAST))
                    begin
                        rv_reg  <= 1'b0; // marks refusal for the place step
                        idx_reg <= idx_reg;
                    end
                end
                else if (idx_reg == LAST)
                    idx_reg <= '0;
                else
                    idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.place_step)
            begin
                if (idx_reg != pos_reg)
                begin
                    kind_reg[idx_reg]   <= kind_reg[idx_reg - 1'b1];
                    size_reg[idx_reg]   <= size_reg[idx_reg - 1'b1];
                    owner_reg[idx_reg]  <= owner_reg[idx_reg - 1'b1];
                    quanta_reg[idx_reg] <= quanta_reg[idx_reg - 1'b1];
                    if (idx_reg == pos_reg + 1'b1)
                    begin
                        kind_reg[idx_reg]   <= KIND_HOLE;
                        size_reg[idx_reg]   <= rest_reg;
                        owner_reg[idx_reg]  <= '0;
                        quanta_reg[idx_reg] <= '0;
                    end
                    idx_reg <= idx_reg - 1'b1;
                end
                else
                begin
                    if (rv_reg)
                    begin
                        kind_reg[pos_reg]   <= KIND_OCC;
                        size_reg[pos_reg]   <= rsize_reg;
                        owner_reg[pos_reg]  <= next_id;
                        quanta_reg[pos_reg] <= rq_reg;
                        last_owner_reg      <= next_id;
                        free_reg            <= free_reg - rsize_reg;
                        active_reg          <= active_reg + 1'b1;
                        adm_reg             <= 1'b1;
                        adm_id_reg          <= next_id;
                        noroom_reg          <= 1'b0;
                    end
                    idx_reg <= '0;
                end
            end
            if (cmd.run_step)
            begin
                if (run_hit)
                begin
                    ran_pos_reg <= idx_reg;
                    ran_reg     <= 1'b1;
                    ran_id_reg  <= owner_reg[idx_reg];
                    ran_left_reg <= (quanta_reg[idx_reg] != '0)
                                    ? quanta_reg[idx_reg] - 1'b1 : '0;
                    turn_reg    <= turn_eff + 1'b1;
                end
                else if (is_occ)
                    count_reg <= count_reg + 1'b1;
                idx_reg <= (idx_reg == LAST || run_hit) ? '0 : idx_reg + 1'b1;
                wr_reg     <= '0;
                wr_any_reg <= 1'b0;
            end
            if (cmd.retire)
            begin
                quanta_reg[ran_pos_reg] <= ran_left_reg;
                if (ran_left_reg == '0)
                begin
                    free_reg  <= free_reg + size_reg[ran_pos_reg];
                    kind_reg[ran_pos_reg]  <= KIND_HOLE;
                    owner_reg[ran_pos_reg] <= '0;
                    active_reg <= active_reg - 1'b1;
                    done_reg  <= 1'b1;
                end
                idx_reg    <= '0;
                wr_reg     <= '0;
                wr_any_reg <= 1'b0;
            end
            if (cmd.pack_step)
            begin
                // read index never trails write index, so in-place copy is safe
                if ((kind_reg[idx_reg] == KIND_HOLE && size_reg[idx_reg] != '0)
                    || is_occ)
                begin
                    if (kind_reg[idx_reg] == KIND_HOLE && wr_any_reg
                        && kind_reg[wr_reg - 1'b1] == KIND_HOLE)
                    begin
                        size_reg[wr_reg - 1'b1] <= size_reg[wr_reg - 1'b1]
                                                   + size_reg[idx_reg];
                        if (idx_reg != wr_reg - 1'b1)
                        begin
                            kind_reg[idx_reg]   <= KIND_UNUSED;
                            size_reg[idx_reg]   <= '0;
                            owner_reg[idx_reg]  <= '0;
                            quanta_reg[idx_reg] <= '0;
                        end
                    end
                    else
                    begin
                        kind_reg[wr_reg]   <= kind_reg[idx_reg];
                        size_reg[wr_reg]   <= size_reg[idx_reg];
                        owner_reg[wr_reg]  <= owner_reg[idx_reg];
                        quanta_reg[wr_reg] <= quanta_reg[idx_reg];
                        if (wr_reg != idx_reg)
                        begin
                            kind_reg[idx_reg]   <= KIND_UNUSED;
                            size_reg[idx_reg]   <= '0;
                            owner_reg[idx_reg]  <= '0;
                            quanta_reg[idx_reg] <= '0;
                        end
                        wr_reg     <= wr_reg + 1'b1;
                        wr_any_reg <= 1'b1;
                    end
                end
                else
                begin
                    kind_reg[idx_reg]   <= KIND_UNUSED;
                    size_reg[idx_reg]   <= '0;
                    owner_reg[idx_reg]  <= '0;
                    quanta_reg[idx_reg] <= '0;
                end
                idx_reg <= (idx_reg == LAST) ? '0 : idx_reg + 1'b1;
            end
            if (cmd.out_load)
                result_reg <= {active_reg, free_reg, done_reg, ran_left_reg, ran_id_reg,
                               ran_reg, noroom_reg, adm_id_reg, adm_reg};
        end
    end

    `ASSERT_CLK(a_active_bound, clk, rst_n, active_reg <= CW'(ENTRIES),
        "active count above table size")
    `ASSERT_CLK(a_adm_excl, clk, rst_n, !(adm_reg && noroom_reg),
        "admitted and refused together")
    `ASSERT_NEXT(a_clear_free, clk, rst_n, cmd.clear, free_reg == mem_size_reg,
        "free units not reloaded on clear")

endmodule
